// File: sv/mcd_pkg.sv
// Shared widths, divisors and month tables for the millisecond to civil date converter.
package mcd_pkg;

  localparam int MS_W    = 49;  // millisecond count
  localparam int REM_W   = 49;  // running remainder of the shared divide unit
  localparam int DIV_W   = 27;  // widest divisor (milliseconds per day)
  localparam int SHIFT_W = 5;   // divisor shift, up to DAY_SHIFT
  localparam int DAY_W   = 23;  // whole day count
  localparam int YQ_W    = 15;  // year estimate and year number
  localparam int DB_W    = 24;  // days before a year
  localparam int DOY_W   = 9;   // day of year, 0 to 365
  localparam int Q100_W  = 8;   // year / 100

  localparam int MAX_YEAR_DEF = 9999;

  localparam logic [DIV_W-1:0] MS_PER_DAY    = 27'd86400000;
  localparam logic [DIV_W-1:0] MS_PER_HOUR   = 27'd3600000;
  localparam logic [DIV_W-1:0] MS_PER_MIN    = 27'd60000;
  localparam logic [DIV_W-1:0] MS_PER_SEC    = 27'd1000;
  localparam logic [DIV_W-1:0] DAYS_PER_YEAR = 27'd365;

  // First divisor shift of each pass, one less than the quotient width.
  localparam logic [SHIFT_W-1:0] DAY_SHIFT  = 5'd22;
  localparam logic [SHIFT_W-1:0] HOUR_SHIFT = 5'd4;
  localparam logic [SHIFT_W-1:0] MIN_SHIFT  = 5'd5;
  localparam logic [SHIFT_W-1:0] SEC_SHIFT  = 5'd5;
  localparam logic [SHIFT_W-1:0] YEAR_SHIFT = 5'd14;

  // n / 100 == (n * 5243) >> 19 for every n below 43699.
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int          DIV100_SH  = 19;

  localparam logic [DOY_W-1:0] CUM_COMMON [12] = '{
    9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };
  localparam logic [DOY_W-1:0] CUM_LEAP [12] = '{
    9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
    9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
  };

endpackage

// File: sv/mcd_div_step.sv
// One restoring divide step: compare the remainder with the shifted divisor and subtract.
module mcd_div_step (
  input  logic [mcd_pkg::REM_W-1:0]   rem,
  input  logic [mcd_pkg::DIV_W-1:0]   divisor,
  input  logic [mcd_pkg::SHIFT_W-1:0] shift,
  output logic [mcd_pkg::REM_W-1:0]   rem_next,
  output logic                        qbit
);

  logic [mcd_pkg::REM_W-1:0] shifted;

  assign shifted  = mcd_pkg::REM_W'(divisor) << shift;
  assign qbit     = (rem >= shifted);
  assign rem_next = qbit ? (rem - shifted) : rem;

endmodule

// File: sv/milliseconds_to_civil_date_top.sv
// Top level: millisecond count to civil date and time of day, one request at a time.
//
// Request channel: req_valid / req_stall carry a millisecond count since
// 0001-01-01 00:00:00.000. A request is taken at a clock edge with req_valid
// high and req_stall low; req_stall stays high while a request is in work.
// Result channel: rsp_valid / rsp_stall carry year, month, day_of_month, hour,
// minute, second, millisecond and out_of_range. Counts that reach the first
// day after year MAX_YEAR give out_of_range = 1 with every other field zero.
// One shared compare-subtract unit produces one quotient bit per cycle: 23
// bits of day count, 5 of hour, 6 of minute, 6 of second and 15 of year
// estimate. The year estimate is then lowered in a loop (days-before
// evaluation, then compare), once plus once per correction, at most about a
// dozen corrections; a last state picks month and day. The next request is
// taken once the unit is back in idle after its result is registered.
// The result sits in an output register: a stalled result holds there while
// the next request is already taken. Should a second result finish while the
// first is still stalled, the unit holds in the month stage until it is taken.
// Reset (rst, synchronous) returns to idle and drops any pending result.
module milliseconds_to_civil_date_top #(
  parameter int MAX_YEAR = mcd_pkg::MAX_YEAR_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [mcd_pkg::MS_W-1:0] milliseconds,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic [13:0]              year,
  output logic [3:0]               month,
  output logic [4:0]               day_of_month,
  output logic [4:0]               hour,
  output logic [5:0]               minute,
  output logic [5:0]               second,
  output logic [9:0]               millisecond,
  output logic                     out_of_range
);

  // First day count past the last reportable year.
  localparam int unsigned DAYS_LIMIT =
    365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;

  typedef enum logic [3:0] {
    S_IDLE, S_DAYS, S_HOUR, S_MIN, S_SEC, S_YEAR, S_YCALC, S_YCHK, S_DATE
  } state_t;

  state_t state;

  logic [mcd_pkg::REM_W-1:0]   rem;
  logic [mcd_pkg::DAY_W-1:0]   quo;
  logic [mcd_pkg::SHIFT_W-1:0] cnt;
  logic [mcd_pkg::DAY_W-1:0]   days;
  logic [4:0]                  hour_q;
  logic [5:0]                  minute_q;
  logic [5:0]                  second_q;
  logic [9:0]                  msec_q;
  logic [mcd_pkg::YQ_W-1:0]    yest;
  logic [mcd_pkg::DB_W-1:0]    db;
  logic [mcd_pkg::DOY_W-1:0]   day_rem;
  logic [mcd_pkg::YQ_W-1:0]    year_num;
  logic [mcd_pkg::Q100_W-1:0]  year_q100;

  logic [mcd_pkg::DIV_W-1:0]   divisor;
  logic [mcd_pkg::REM_W-1:0]   rem_next;
  logic                        qbit;
  logic [mcd_pkg::DAY_W-1:0]   quo_next;
  logic [mcd_pkg::YQ_W-1:0]    yest_inc;

  logic                        div100_zero;
  logic                        leap;
  logic [3:0]                  month_idx;
  logic [mcd_pkg::DOY_W-1:0]   month_before;
  logic [4:0]                  dom;
  logic                        beyond;

  // Days in whole years 1 .. n.
  function automatic logic [mcd_pkg::DB_W-1:0] days_before(
    input logic [mcd_pkg::YQ_W-1:0] n
  );
    logic [27:0]               prod;
    logic [mcd_pkg::DB_W-1:0]  q100;
    prod = 28'(n) * 28'(mcd_pkg::DIV100_MUL);
    q100 = mcd_pkg::DB_W'(prod >> mcd_pkg::DIV100_SH);
    return mcd_pkg::DB_W'(n) * mcd_pkg::DB_W'(365) + mcd_pkg::DB_W'(n >> 2)
           - q100 + (q100 >> 2);
  endfunction

  function automatic logic [mcd_pkg::Q100_W-1:0] div100(
    input logic [mcd_pkg::YQ_W-1:0] n
  );
    logic [27:0] prod;
    prod = 28'(n) * 28'(mcd_pkg::DIV100_MUL);
    return mcd_pkg::Q100_W'(prod >> mcd_pkg::DIV100_SH);
  endfunction

  assign req_stall = (state != S_IDLE);

  // Pick the divisor of the pass in work.
  always_comb begin
    unique case (state)
      S_DAYS:  divisor = mcd_pkg::MS_PER_DAY;
      S_HOUR:  divisor = mcd_pkg::MS_PER_HOUR;
      S_MIN:   divisor = mcd_pkg::MS_PER_MIN;
      S_SEC:   divisor = mcd_pkg::MS_PER_SEC;
      S_YEAR:  divisor = mcd_pkg::DAYS_PER_YEAR;
      default: divisor = '0;
    endcase
  end

  mcd_div_step u_step (
    .rem      (rem),
    .divisor  (divisor),
    .shift    (cnt),
    .rem_next (rem_next),
    .qbit     (qbit)
  );

  assign quo_next = {quo[mcd_pkg::DAY_W-2:0], qbit};
  assign yest_inc = yest + 1'b1;

  // Leap year from the registered year / 100, then month by table search.
  always_comb begin
    div100_zero = (mcd_pkg::YQ_W'(year_q100) * mcd_pkg::YQ_W'(100)) == year_num;
    leap = ((year_num[1:0] == 2'd0) && !div100_zero) ||
           (div100_zero && (year_q100[1:0] == 2'd0));
    month_idx = '0;
    for (int k = 0; k < 11; k++) begin
      if ((leap ? mcd_pkg::CUM_LEAP[k] : mcd_pkg::CUM_COMMON[k]) <= day_rem) begin
        month_idx = month_idx + 4'd1;
      end
    end
    if (month_idx == 4'd0) begin
      month_before = '0;
    end else if (leap) begin
      month_before = mcd_pkg::CUM_LEAP[month_idx - 4'd1];
    end else begin
      month_before = mcd_pkg::CUM_COMMON[month_idx - 4'd1];
    end
    dom    = 5'(day_rem - month_before + 1'b1);
    beyond = (32'(days) >= DAYS_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one replaces it.
      if (rsp_valid && !rsp_stall && (state != S_DATE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            rem   <= mcd_pkg::REM_W'(milliseconds);
            quo   <= '0;
            cnt   <= mcd_pkg::DAY_SHIFT;
            state <= S_DAYS;
          end
        end
        S_DAYS: begin
          rem <= rem_next;
          if (cnt == '0) begin
            days  <= quo_next;
            quo   <= '0;
            cnt   <= mcd_pkg::HOUR_SHIFT;
            state <= S_HOUR;
          end else begin
            quo <= quo_next;
            cnt <= cnt - 1'b1;
          end
        end
        S_HOUR: begin
          rem <= rem_next;
          if (cnt == '0) begin
            hour_q <= quo_next[4:0];
            quo    <= '0;
            cnt    <= mcd_pkg::MIN_SHIFT;
            state  <= S_MIN;
          end else begin
            quo <= quo_next;
            cnt <= cnt - 1'b1;
          end
        end
        S_MIN: begin
          rem <= rem_next;
          if (cnt == '0) begin
            minute_q <= quo_next[5:0];
            quo      <= '0;
            cnt      <= mcd_pkg::SEC_SHIFT;
            state    <= S_SEC;
          end else begin
            quo <= quo_next;
            cnt <= cnt - 1'b1;
          end
        end
        S_SEC: begin
          if (cnt == '0) begin
            second_q <= quo_next[5:0];
            msec_q   <= rem_next[9:0];
            rem      <= mcd_pkg::REM_W'(days);
            quo      <= '0;
            cnt      <= mcd_pkg::YEAR_SHIFT;
            state    <= S_YEAR;
          end else begin
            rem <= rem_next;
            quo <= quo_next;
            cnt <= cnt - 1'b1;
          end
        end
        S_YEAR: begin
          rem <= rem_next;
          if (cnt == '0) begin
            yest  <= quo_next[mcd_pkg::YQ_W-1:0];
            state <= S_YCALC;
          end else begin
            quo <= quo_next;
            cnt <= cnt - 1'b1;
          end
        end
        S_YCALC: begin
          db    <= days_before(yest);
          state <= S_YCHK;
        end
        S_YCHK: begin
          if ((yest != '0) && (db > mcd_pkg::DB_W'(days))) begin
            yest  <= yest - 1'b1;
            state <= S_YCALC;
          end else begin
            day_rem   <= mcd_pkg::DOY_W'(mcd_pkg::DB_W'(days) - db);
            year_num  <= yest_inc;
            year_q100 <= div100(yest_inc);
            state     <= S_DATE;
          end
        end
        S_DATE: begin
          // Hold here until the output register is free.
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            if (beyond) begin
              year         <= '0;
              month        <= '0;
              day_of_month <= '0;
              hour         <= '0;
              minute       <= '0;
              second       <= '0;
              millisecond  <= '0;
              out_of_range <= 1'b1;
            end else begin
              year         <= year_num[13:0];
              month        <= month_idx + 4'd1;
              day_of_month <= dom;
              hour         <= hour_q;
              minute       <= minute_q;
              second       <= second_q;
              millisecond  <= msec_q;
              out_of_range <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // A taken request keeps the unit busy in the next cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken but unit not busy");

  // An out-of-range result carries no date or time.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && out_of_range) |->
      (year == '0 && month == '0 && day_of_month == '0 && hour == '0 &&
       minute == '0 && second == '0 && millisecond == '0))
    else $error("out-of-range result with nonzero fields");

  // A normal result lies within calendar and clock limits.
  a_fields_legal: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !out_of_range) |->
      (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1 &&
       hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 &&
       millisecond <= 10'd999))
    else $error("result field out of its range");
`endif

endmodule

// File: verif/milliseconds_to_civil_date_top_tb.sv
// Self-checking testbench for the millisecond count to civil date converter.
module milliseconds_to_civil_date_top_tb;

  // Calendar constants of the predictor. The last valid count is the final
  // millisecond of 9999-12-31, and the last day number belongs to that date.
  localparam longint unsigned MS_PER_DAY_TB = 64'd86400000;
  localparam longint unsigned LAST_YEAR     = 64'd9999;
  localparam longint unsigned LAST_DAY_NUM  = 64'd3652058;
  localparam longint unsigned LAST_VALID_MS = 64'd315537897599999;
  localparam longint unsigned MS_FIELD_MAX  = 64'h1_FFFF_FFFF_FFFF;
  localparam longint unsigned TOD_MAX       = 64'd86399999;

  localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  // Day-of-year offsets around month and year edges: Feb 28 / Mar 1 in
  // common years, end of June / start of July, Dec 31 / day after.
  localparam int YEAR_MARKS [7] = '{0, 58, 59, 180, 181, 364, 365};

  localparam int RANDOM_PER_PHASE = 463;
  localparam int DRAIN_CYCLES     = 150;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int REPORT_LIMIT     = 10;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic        out_of_range;
  } civil_date_t;

  // One row of the directed table: the count, and a typed-in date where
  // the answer is obvious; other rows are predicted.
  typedef struct {
    logic [mcd_pkg::MS_W-1:0] ms;
    bit                       typed;
    civil_date_t              want;
  } stim_row_t;

  typedef struct {
    logic [mcd_pkg::MS_W-1:0] ms;
    civil_date_t              want;
  } pending_date_t;

  logic                     clk;
  logic                     rst          = 1'b1;
  logic                     req_valid    = 1'b0;
  logic                     req_stall;
  logic [mcd_pkg::MS_W-1:0] milliseconds = '0;
  logic                     rsp_valid;
  logic                     rsp_stall    = 1'b0;
  logic [13:0]              year;
  logic [3:0]               month;
  logic [4:0]               day_of_month;
  logic [4:0]               hour;
  logic [5:0]               minute;
  logic [5:0]               second;
  logic [9:0]               millisecond;
  logic                     out_of_range;

  stim_row_t     directed_rows [$];
  pending_date_t pending_dates [$];
  pending_date_t oldest_date;
  civil_date_t   got_date;
  string         diff_names;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int beyond_count   = 0;
  int leap_day_count = 0;
  int cycles_run     = 0;

  milliseconds_to_civil_date_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .milliseconds (milliseconds),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .millisecond  (millisecond),
    .out_of_range (out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // Days in the first n whole years of the calendar.
  function automatic longint unsigned days_through(longint unsigned n);
    return 365 * n + n / 4 - n / 100 + n / 400;
  endfunction

  function automatic bit leap_year(longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic civil_date_t predict_civil_date(logic [mcd_pkg::MS_W-1:0] ms);
    civil_date_t     d;
    longint unsigned days, tod, y, doy, first;
    int              mon, len;
    d    = '0;
    days = ms / MS_PER_DAY_TB;
    tod  = ms % MS_PER_DAY_TB;
    // Anything from the day after 9999-12-31 on is flagged, all else zero.
    if (days >= days_through(LAST_YEAR)) begin
      d.out_of_range = 1'b1;
      return d;
    end
    // Estimate whole years elapsed, then back off past the leap-day surplus.
    y = days / 365;
    while (y > 0 && days_through(y) > days) y--;
    doy   = days - days_through(y);
    first = 0;
    mon   = 0;
    while (mon < 11) begin
      len = MONTH_LEN[mon] + ((mon == 1 && leap_year(y + 1)) ? 1 : 0);
      if (doy < first + len) break;
      first += len;
      mon++;
    end
    d.year         = 14'(y + 1);
    d.month        = 4'(mon + 1);
    d.day_of_month = 5'(doy - first + 1);
    d.hour         = 5'(tod / 3600000);
    d.minute       = 6'((tod / 60000) % 60);
    d.second       = 6'((tod / 1000) % 60);
    d.millisecond  = 10'(tod % 1000);
    return d;
  endfunction

  // ----------------------------------------------------------------- stimulus

  function automatic logic [mcd_pkg::MS_W-1:0] ms_at(longint unsigned days,
                                                     longint unsigned tod);
    return mcd_pkg::MS_W'(days * MS_PER_DAY_TB + tod);
  endfunction

  // Most counts land inside the calendar, with weight on year and month
  // edges, the first years and the last days; the rest lie past year 9999
  // or are raw 49-bit patterns so every input bit toggles.
  function automatic logic [mcd_pkg::MS_W-1:0] random_milliseconds();
    longint unsigned days, tod, wide, y;
    int              kind;
    kind = $urandom_range(99);
    wide = {$urandom(), $urandom()};
    case ($urandom_range(3))
      0:       tod = 0;
      1:       tod = TOD_MAX;
      default: tod = $urandom_range(32'(TOD_MAX));
    endcase
    if (kind < 40) begin
      days = $urandom_range(32'(LAST_DAY_NUM));
    end else if (kind < 60) begin
      y    = $urandom_range(32'(LAST_YEAR), 1);
      days = days_through(y - 1) + YEAR_MARKS[$urandom_range(6)];
      if ($urandom_range(1) == 1 && days > 0) days = days - 1;
    end else if (kind < 70) begin
      days = $urandom_range(1500);
    end else if (kind < 78) begin
      days = LAST_DAY_NUM - $urandom_range(366) + $urandom_range(2);
    end else if (kind < 88) begin
      return mcd_pkg::MS_W'(LAST_VALID_MS + 1 + wide % (MS_FIELD_MAX - LAST_VALID_MS));
    end else begin
      return wide[mcd_pkg::MS_W-1:0];
    end
    return ms_at(days, tod);
  endfunction

  task automatic add_row(logic [mcd_pkg::MS_W-1:0] ms, bit typed, civil_date_t want);
    stim_row_t row;
    row.ms    = ms;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Drive one request at the falling edge, after an optional random gap,
  // and hold it until the converter takes it; then queue what it must give.
  task automatic send_request(logic [mcd_pkg::MS_W-1:0] ms, civil_date_t want);
    pending_date_t entry;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid    <= 1'b1;
    milliseconds <= ms;
    forever begin
      @(posedge clk);
      if (!req_stall) break;
    end
    entry.ms   = ms;
    entry.want = want;
    pending_dates.push_back(entry);
    requests_sent++;
  endtask

  // Drop valid and hold off until every queued date has come back.
  task automatic wait_for_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  // ----------------------------------------------------------------- checking

  function automatic string format_date(civil_date_t d);
    return $sformatf("%0d-%0d-%0d %0d:%0d:%0d.%0d oor=%0b", d.year, d.month,
                     d.day_of_month, d.hour, d.minute, d.second, d.millisecond,
                     d.out_of_range);
  endfunction

  function automatic string differing_fields(civil_date_t want, civil_date_t got);
    string s;
    s = "";
    if (got.year !== want.year)                 s = {s, " year"};
    if (got.month !== want.month)               s = {s, " month"};
    if (got.day_of_month !== want.day_of_month) s = {s, " day_of_month"};
    if (got.hour !== want.hour)                 s = {s, " hour"};
    if (got.minute !== want.minute)             s = {s, " minute"};
    if (got.second !== want.second)             s = {s, " second"};
    if (got.millisecond !== want.millisecond)   s = {s, " millisecond"};
    if (got.out_of_range !== want.out_of_range) s = {s, " out_of_range"};
    return s;
  endfunction

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endtask

  // Receiver: redraw the stall at every falling edge from the phase's odds.
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Take each result at the rising edge it is accepted and match it
  // against the oldest queued date.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      got_date = '{year, month, day_of_month, hour, minute, second, millisecond,
                   out_of_range};
      if (pending_dates.size() == 0) begin
        note_failure($sformatf("result with no request waiting: %s",
                               format_date(got_date)));
      end else begin
        oldest_date = pending_dates.pop_front();
        diff_names  = differing_fields(oldest_date.want, got_date);
        if (diff_names != "") begin
          note_failure($sformatf("ms=%0d wrong:%s expected %s got %s", oldest_date.ms,
                                 diff_names, format_date(oldest_date.want),
                                 format_date(got_date)));
        end
        results_seen++;
        if (got_date.out_of_range) beyond_count++;
        if (got_date.month == 4'd2 && got_date.day_of_month == 5'd29) leap_day_count++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d dates still queued", cycles_run,
               pending_dates.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ------------------------------------------------------------------- script

  initial begin
    int phase;
    int n;
    // Hold reset at the start, release it at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: field extremes, day and year edges, the end-of-June
    // boundary, leap rules for years 4, 100, 400 and 2000, and the region
    // beyond year 9999 up to the all-ones count.
    add_row(49'd0, 1'b1, '{14'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0, 1'b0});
    add_row(49'd999, 1'b0, '0);
    add_row(49'd59999, 1'b0, '0);
    add_row(49'd3599999, 1'b0, '0);
    add_row(ms_at(0, TOD_MAX), 1'b1,
            '{14'd1, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, 10'd999, 1'b0});
    add_row(ms_at(1, 0), 1'b0, '0);
    add_row(ms_at(30, 43200000), 1'b0, '0);     // Jan 31, noon
    add_row(ms_at(31, 0), 1'b0, '0);            // Feb 1
    add_row(ms_at(180, TOD_MAX), 1'b0, '0);     // June 30, last millisecond
    add_row(ms_at(181, 0), 1'b0, '0);           // July 1
    add_row(ms_at(364, TOD_MAX), 1'b0, '0);     // end of year 1
    add_row(ms_at(365, 0), 1'b0, '0);           // start of year 2
    add_row(ms_at(1154, 0), 1'b0, '0);          // Feb 29 of year 4
    add_row(ms_at(1460, TOD_MAX), 1'b0, '0);    // Dec 31 of leap year 4
    add_row(ms_at(36523, 0), 1'b0, '0);         // Dec 31 of century year 100
    add_row(ms_at(36524, 0), 1'b0, '0);         // Jan 1 of year 101
    add_row(ms_at(146096, 0), 1'b0, '0);        // Dec 31 of year 400
    add_row(ms_at(730178, 3723004), 1'b0, '0);  // Feb 29 of year 2000
    add_row(49'h1_0000_0000_0000, 1'b0, '0);    // top input bit alone
    add_row(49'(LAST_VALID_MS), 1'b1,
            '{14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999, 1'b0});
    add_row(49'(LAST_VALID_MS + 1), 1'b1, '{14'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 10'd0, 1'b1});
    add_row(49'(MS_FIELD_MAX), 1'b1, '{14'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 10'd0, 1'b1});

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].ms, directed_rows[i].typed ?
                   directed_rows[i].want : predict_civil_date(directed_rows[i].ms));
    end
    // Let the pipeline run dry before the random part.
    wait_for_results();

    // Random requests in four idling phases: none, sender mostly idle,
    // receiver mostly stalled, both lightly; drain between phases.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        logic [mcd_pkg::MS_W-1:0] ms;
        ms = random_milliseconds();
        send_request(ms, predict_civil_date(ms));
      end
      wait_for_results();
    end

    // Watch a while longer for stray results.
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (pending_dates.size() != 0) begin
      oldest_date = pending_dates.pop_front();
      note_failure($sformatf("no result for ms=%0d, expected %s", oldest_date.ms,
                             format_date(oldest_date.want)));
    end

    $display("covered %0d requests (%0d directed), %0d results checked, %0d mismatches",
             requests_sent, directed_rows.size(), results_seen, mismatches);
    $display("%0d past year 9999, %0d on Feb 29, idling none/sender/receiver/both",
             beyond_count, leap_day_count);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mcd_pkg.sv
sv/mcd_div_step.sv
sv/milliseconds_to_civil_date_top.sv
verif/milliseconds_to_civil_date_top_tb.sv
